[design/uv_sphere_mesh_generator_core_macros.svh]
// Assertion macros shared by the sphere generator RTL.
`ifndef UV_SPHERE_MESH_GENERATOR_CORE_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, held off during reset.
`define UVSG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, held off during reset.
`define UVSG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/uvsg_pkg.sv]
// Types, codes and constants of the UV-sphere generator.
package uvsg_pkg;

    localparam int IDX_W        = 9;
    localparam int RAD_W        = 15;
    localparam int VIDX_W       = 17;
    localparam int FX_W         = 16;
    localparam int KIND_W       = 2;
    localparam int QUO_W        = 33;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_W     = 34;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 15;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STACKS  = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST  = 15'd16384;
    localparam logic [IDX_W-1:0] SECTORS_RST = 9'd32;
    localparam logic [IDX_W-1:0] STACKS_RST  = 9'd16;

    localparam logic [KIND_W-1:0] KIND_VTX  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MORE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LAST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

    localparam logic [1:0] CLS_VTX  = 2'd0;
    localparam logic [1:0] CLS_TRI  = 2'd1;
    localparam logic [1:0] CLS_ERR  = 2'd2;
    localparam logic [1:0] CLS_NONE = 2'd3;

    localparam logic [0:0] OP_VERTEX = 1'b0;
    localparam logic [0:0] OP_CELL   = 1'b1;

    localparam logic [31:0] PHASE_QTR  = 32'h4000_0000;
    localparam logic [31:0] PHASE_HALF_QTR = 32'h2000_0000;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [31:0] ATAN_TURN [CORDIC_ITERS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
        32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
        32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215,
        32'sd2608, 32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81,
        32'sd41, 32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1
    };

    typedef struct packed {
        logic [0:0]       opcode;
        logic [IDX_W-1:0] stack_index;
        logic [IDX_W-1:0] sector_index;
    } t_in_beat;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [FX_W-1:0]  pos_x;
        logic signed [FX_W-1:0]  pos_y;
        logic signed [FX_W-1:0]  pos_z;
        logic signed [FX_W-1:0]  norm_x;
        logic signed [FX_W-1:0]  norm_y;
        logic signed [FX_W-1:0]  norm_z;
        logic [FX_W-1:0]         tex_u;
        logic [FX_W-1:0]         tex_v;
        logic [VIDX_W-1:0]       tri_a;
        logic [VIDX_W-1:0]       tri_b;
        logic [VIDX_W-1:0]       tri_c;
    } t_out_beat;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [IDX_W-1:0] sector_count;
        logic [IDX_W-1:0] stack_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        cls;
        logic [IDX_W-1:0]  stack_index;
        logic [IDX_W-1:0]  sector_index;
        logic [VIDX_W-1:0] k1;
        logic [VIDX_W-1:0] k2;
        logic              has_t1;
        logic              has_t2;
    } t_cmd;

    typedef struct packed {
        t_cmd            cmd;
        logic [FX_W-1:0] tex_u;
        logic [FX_W-1:0] tex_v;
    } t_slot;

endpackage

[design/uv_sphere_mesh_generator_core.sv]
// UV-sphere mesh element generator, top level.
// Input channel (i_in_valid/o_in_ready, i_in): one request per beat, opcode 0
//   asks for vertex (stack, sector), opcode 1 for the triangles of a grid cell.
// Output channel (o_out_valid/i_out_ready, o_out): one vertex, one or two
//   triangles, or an error (bad index or configuration) per request; a cell on a
//   one-stack sphere gives no beat.
// Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): radius,
//   sector count, stack count; always ready. The user must see that they are
//   written only while idle; the block itself does not enforce this.
// Pipeline: the 33-stage divider, the 32-stage CORDIC and two multiply stages,
//   plus queue and output register.
// Throughput: one request per cycle while the receiver takes each beat; a
//   two-triangle cell gives two beats and holds the pipeline for the first.
// Reset: configuration returns to radius 1.0, 32 sectors, 16 stacks; pipeline
//   and queue empty.
// When the receiver stalls the pipeline freezes, a four-entry queue absorbs
//   requests, then o_in_ready drops.
module uv_sphere_mesh_generator_core import uvsg_pkg::*; #(
    parameter int MAX_SECTORS = 256,
    parameter int MAX_STACKS  = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic push;
    logic full;
    logic q_pop;
    logic q_valid;
    t_cmd f_cmd;
    t_cmd q_cmd;
    t_cfg cfg;

    uvsg_front #(
        .MAX_SECTORS (MAX_SECTORS),
        .MAX_STACKS  (MAX_STACKS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .i_full      (full),
        .o_cfg       (cfg)
    );

    uvsg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    uvsg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[design/uvsg_front.sv]
// Front end: configuration registers, request checks and cell index maths.
module uvsg_front import uvsg_pkg::*; #(
    parameter int MAX_SECTORS = 256,
    parameter int MAX_STACKS  = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    input  logic                  i_full,
    output t_cfg                  o_cfg
);

    t_cfg              r_cfg;
    logic              cfg_ok;
    logic              err;
    logic              has_t1;
    logic              has_t2;
    logic [VIDX_W+1:0] k1w;
    logic [VIDX_W+1:0] k2w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius       <= RADIUS_RST;
            r_cfg.sector_count <= SECTORS_RST;
            r_cfg.stack_count  <= STACKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RADIUS:  r_cfg.radius       <= i_cfg_data[RAD_W-1:0];
                REG_SECTORS: r_cfg.sector_count <= i_cfg_data[IDX_W-1:0];
                REG_STACKS:  r_cfg.stack_count  <= i_cfg_data[IDX_W-1:0];
                default:     r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        cfg_ok = (r_cfg.sector_count != '0) && (32'(r_cfg.sector_count) <= MAX_SECTORS)
              && (r_cfg.stack_count != '0) && (32'(r_cfg.stack_count) <= MAX_STACKS);
        if (i_in.opcode == OP_VERTEX) begin
            err = !cfg_ok || (i_in.stack_index > r_cfg.stack_count)
                || (i_in.sector_index > r_cfg.sector_count);
        end else begin
            err = !cfg_ok || (i_in.stack_index >= r_cfg.stack_count)
                || (i_in.sector_index >= r_cfg.sector_count);
        end
        has_t1 = i_in.stack_index != '0;
        has_t2 = i_in.stack_index != (r_cfg.stack_count - 9'd1);
        k1w = 19'({10'd0, i_in.stack_index} * ({10'd0, r_cfg.sector_count} + 19'd1))
            + {10'd0, i_in.sector_index};
        k2w = k1w + {10'd0, r_cfg.sector_count} + 19'd1;

        o_cmd.stack_index  = i_in.stack_index;
        o_cmd.sector_index = i_in.sector_index;
        o_cmd.k1           = k1w[VIDX_W-1:0];
        o_cmd.k2           = k2w[VIDX_W-1:0];
        o_cmd.has_t1       = has_t1;
        o_cmd.has_t2       = has_t2;
        priority if (err) begin
            o_cmd.cls = CLS_ERR;
        end else if (i_in.opcode == OP_VERTEX) begin
            o_cmd.cls = CLS_VTX;
        end else if (!has_t1 && !has_t2) begin
            o_cmd.cls = CLS_NONE;
        end else begin
            o_cmd.cls = CLS_TRI;
        end
    end

    assign o_in_ready  = !i_full;
    assign o_push      = i_in_valid && !i_full;
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

[design/uvsg_fifo.sv]
// Short command queue between front and back ends.
module uvsg_fifo import uvsg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];

endmodule

[design/uvsg_div.sv]
// Pipelined restoring divider: floor(num * 2^32 / den), one quotient bit per stage.
module uvsg_div import uvsg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_num,
    input  logic [IDX_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    logic [IDX_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [IDX_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_quo [QUO_W];
    logic [IDX_W:0]   sh    [QUO_W];
    logic             ge    [QUO_W];

    always_comb begin
        sh[0]    = {1'b0, i_num};
        ge[0]    = sh[0] >= {1'b0, i_den};
        n_rem[0] = ge[0] ? IDX_W'(sh[0] - {1'b0, i_den}) : sh[0][IDX_W-1:0];
        n_quo[0] = {{(QUO_W-1){1'b0}}, ge[0]};
        for (int k = 1; k < QUO_W; k++) begin
            sh[k]    = {r_rem[k-1], 1'b0};
            ge[k]    = sh[k] >= {1'b0, i_den};
            n_rem[k] = ge[k] ? IDX_W'(sh[k] - {1'b0, i_den}) : sh[k][IDX_W-1:0];
            n_quo[k] = {r_quo[k-1][QUO_W-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

[design/uvsg_cordic.sv]
// Pipelined CORDIC sine/cosine with quadrant fold and Q14 rounding.
module uvsg_cordic import uvsg_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [31:0]            i_phase,
    output logic signed [FX_W-1:0] o_cos,
    output logic signed [FX_W-1:0] o_sin
);

    logic signed [CORDIC_W-1:0] r_x [CORDIC_ITERS+1];
    logic signed [CORDIC_W-1:0] r_y [CORDIC_ITERS+1];
    logic signed [31:0]         r_z [CORDIC_ITERS+1];
    logic [1:0]                 r_q [CORDIC_ITERS+1];
    logic signed [CORDIC_W-1:0] n_x [CORDIC_ITERS+1];
    logic signed [CORDIC_W-1:0] n_y [CORDIC_ITERS+1];
    logic signed [31:0]         n_z [CORDIC_ITERS+1];
    logic [31:0]                ph_adj;
    logic [1:0]                 q;
    logic [31:0]                d;
    logic signed [CORDIC_W-1:0] xr;
    logic signed [CORDIC_W-1:0] yr;
    logic signed [FX_W-1:0]     c;
    logic signed [FX_W-1:0]     s;
    logic signed [FX_W-1:0]     r_cos;
    logic signed [FX_W-1:0]     r_sin;

    function automatic logic signed [FX_W-1:0] clamp_q14(input logic signed [17:0] v);
        logic signed [FX_W-1:0] res;
        if (v > 18'sd16384)       res = 16'sd16384;
        else if (v < -18'sd16384) res = -16'sd16384;
        else                      res = v[FX_W-1:0];
        return res;
    endfunction

    always_comb begin
        ph_adj = i_phase + PHASE_HALF_QTR;
        q      = ph_adj[31:30];
        d      = i_phase - {q, 30'd0};
        n_x[0] = CORDIC_GAIN;
        n_y[0] = '0;
        n_z[0] = $signed(d);
        for (int k = 0; k < CORDIC_ITERS; k++) begin
            if (!r_z[k][31]) begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_z[k+1] = r_z[k] - ATAN_TURN[k];
            end else begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_z[k+1] = r_z[k] + ATAN_TURN[k];
            end
        end
        xr = r_x[CORDIC_ITERS] + 34'sd32768;
        yr = r_y[CORDIC_ITERS] + 34'sd32768;
        c  = clamp_q14(xr[CORDIC_W-1:16]);
        s  = clamp_q14(yr[CORDIC_W-1:16]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= CORDIC_ITERS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            r_q[0] <= q;
            for (int k = 1; k <= CORDIC_ITERS; k++) r_q[k] <= r_q[k-1];
            unique case (r_q[CORDIC_ITERS])
                2'd0: begin r_cos <= c;  r_sin <= s;  end
                2'd1: begin r_cos <= -s; r_sin <= c;  end
                2'd2: begin r_cos <= -c; r_sin <= -s; end
                2'd3: begin r_cos <= s;  r_sin <= -c; end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[design/uvsg_back.sv]
// Back end: divide, trig and scale pipeline, triangle expansion and output register.
module uvsg_back import uvsg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    `include "uv_sphere_mesh_generator_core_macros.svh"

    localparam int DIV_LAT   = QUO_W;
    localparam int COR_LAT   = CORDIC_ITERS + 2;
    localparam int TEX_SLOT  = DIV_LAT + 1;
    localparam int NSLOT     = DIV_LAT + COR_LAT + 3;
    localparam int LAST_SLOT = NSLOT - 1;

    logic [NSLOT-1:0]       r_vld;
    t_slot                  r_slot [NSLOT];
    logic [QUO_W-1:0]       quo_a;
    logic [QUO_W-1:0]       quo_b;
    logic [31:0]            ph_a;
    logic [31:0]            ph_b;
    logic signed [FX_W-1:0] ca;
    logic signed [FX_W-1:0] sa;
    logic signed [FX_W-1:0] cb;
    logic signed [FX_W-1:0] sb;
    logic signed [FX_W-1:0] rad_s;
    logic signed [31:0]     r_cc;
    logic signed [31:0]     r_cs;
    logic signed [31:0]     r_rs;
    logic signed [FX_W-1:0] r_sa;
    logic signed [47:0]     m_px;
    logic signed [47:0]     m_py;
    logic signed [31:0]     t_nx;
    logic signed [31:0]     t_ny;
    logic signed [31:0]     t_pz;
    logic signed [FX_W-1:0] r_px;
    logic signed [FX_W-1:0] r_py;
    logic signed [FX_W-1:0] r_pz;
    logic signed [FX_W-1:0] r_nx;
    logic signed [FX_W-1:0] r_ny;
    logic signed [FX_W-1:0] r_nz;
    t_slot                  e;
    logic                   e_v;
    logic                   need2;
    logic                   sel2;
    logic                   out_load;
    logic                   load_beat;
    logic                   pop;
    logic                   adv;
    logic                   r_half;
    logic                   r_out_valid;
    t_out_beat              r_out;
    t_out_beat              beat;
    logic [VIDX_W-1:0]      k1p;
    logic [VIDX_W-1:0]      k2p;

    assign e         = r_slot[LAST_SLOT];
    assign e_v       = r_vld[LAST_SLOT];
    assign need2     = e.cmd.has_t1 && e.cmd.has_t2;
    assign out_load  = !r_out_valid || i_out_ready;
    assign load_beat = out_load && e_v && (e.cmd.cls != CLS_NONE);
    assign pop       = e_v && ((e.cmd.cls == CLS_NONE)
                     || (out_load && !((e.cmd.cls == CLS_TRI) && need2 && !r_half)));
    assign adv       = !e_v || pop;
    assign o_q_pop   = adv && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSLOT-2:0], i_q_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_slot[0] <= '{cmd: i_q_cmd, tex_u: '0, tex_v: '0};
            for (int k = 1; k < NSLOT; k++) begin
                if (k == TEX_SLOT) begin
                    r_slot[k] <= '{cmd: r_slot[k-1].cmd, tex_u: quo_b[QUO_W-1:QUO_W-FX_W],
                                   tex_v: quo_a[QUO_W-1:QUO_W-FX_W]};
                end else begin
                    r_slot[k] <= r_slot[k-1];
                end
            end
        end
    end

    uvsg_div u_div_a (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_slot[0].cmd.stack_index),
        .i_den (i_cfg.stack_count),
        .o_quo (quo_a)
    );

    uvsg_div u_div_b (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_slot[0].cmd.sector_index),
        .i_den (i_cfg.sector_count),
        .o_quo (quo_b)
    );

    assign ph_a = PHASE_QTR - quo_a[QUO_W-1:1];
    assign ph_b = quo_b[31:0];

    uvsg_cordic u_cordic_a (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (ph_a),
        .o_cos   (ca),
        .o_sin   (sa)
    );

    uvsg_cordic u_cordic_b (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_phase (ph_b),
        .o_cos   (cb),
        .o_sin   (sb)
    );

    assign rad_s = $signed({1'b0, i_cfg.radius});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cc <= ca * cb;
            r_cs <= ca * sb;
            r_rs <= rad_s * sa;
            r_sa <= sa;
        end
    end

    always_comb begin
        m_px = rad_s * r_cc + (48'sd1 <<< 27);
        m_py = rad_s * r_cs + (48'sd1 <<< 27);
        t_nx = r_cc + 32'sd8192;
        t_ny = r_cs + 32'sd8192;
        t_pz = r_rs + 32'sd8192;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px <= m_px[43:28];
            r_py <= m_py[43:28];
            r_pz <= t_pz[29:14];
            r_nx <= t_nx[29:14];
            r_ny <= t_ny[29:14];
            r_nz <= r_sa;
        end
    end

    always_comb begin
        beat = '0;
        sel2 = r_half || !e.cmd.has_t1;
        k1p  = e.cmd.k1 + 17'd1;
        k2p  = e.cmd.k2 + 17'd1;
        unique case (e.cmd.cls)
            CLS_VTX: begin
                beat.kind   = KIND_VTX;
                beat.pos_x  = r_px;
                beat.pos_y  = r_py;
                beat.pos_z  = r_pz;
                beat.norm_x = r_nx;
                beat.norm_y = r_ny;
                beat.norm_z = r_nz;
                beat.tex_u  = e.tex_u;
                beat.tex_v  = e.tex_v;
            end
            CLS_TRI: begin
                beat.kind  = (need2 && !r_half) ? KIND_MORE : KIND_LAST;
                beat.tri_a = sel2 ? k1p : e.cmd.k1;
                beat.tri_b = e.cmd.k2;
                beat.tri_c = sel2 ? k2p : k1p;
            end
            CLS_ERR:  beat.kind = KIND_ERR;
            CLS_NONE: beat.kind = KIND_ERR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= load_beat;
            if (load_beat && (e.cmd.cls == CLS_TRI) && need2) r_half <= !r_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_beat) r_out <= beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `UVSG_ASSERT_NOW(a_half_after_more, r_half, r_out_valid && (r_out.kind == KIND_MORE), "second triangle pending without first one shown")
    `UVSG_ASSERT_NOW(a_err_clean, r_out_valid && (r_out.kind == KIND_ERR), (r_out.tri_a == '0) && (r_out.pos_x == '0) && (r_out.tex_u == '0), "error beat carries data")
    `UVSG_ASSERT_NOW(a_vtx_no_tri, r_out_valid && (r_out.kind == KIND_VTX), (r_out.tri_a == '0) && (r_out.tri_b == '0) && (r_out.tri_c == '0), "vertex beat carries indices")
    `UVSG_ASSERT_NXT(a_end_hold, e_v && !pop, r_vld[LAST_SLOT], "pipeline tail lost while held")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the UV-sphere mesh generator core.
`timescale 1ns / 1ps
module tb_top;
    import uvsg_pkg::*;

    localparam int LATENCY   = 69;
    localparam int CYCLE_CAP = 2000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    uv_sphere_mesh_generator_core dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    int unsigned sph_radius, sph_sectors, sph_stacks;
    t_out_beat   mesh_expected[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          hold_off = 0;
    bit          out_idle_en = 1'b1;
    longint      atan_tab[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1};

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    task automatic phase_trig(input bit [31:0] phase, output longint cs, output longint sn);
        bit [31:0] q, d;
        longint    x, y, z, dx, dy, c, s;
        q = ((phase + 32'h2000_0000) >> 30) & 3;
        d = phase - (q << 30);
        z = longint'($signed(d));
        x = 652032874;
        y = 0;
        for (int k = 0; k < 30; k++) begin
            dx = floor_sh(y, k);
            dy = floor_sh(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[k];
            end else begin
                x += dx; y -= dy; z += atan_tab[k];
            end
        end
        c = unit_clamp(round_sh(x, 16));
        s = unit_clamp(round_sh(y, 16));
        case (q)
            0: begin cs = c;  sn = s;  end
            1: begin cs = -s; sn = c;  end
            2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
    endtask

    task automatic predict_mesh(input t_in_beat req);
        longint    i, j, ns, nt, ca, sa, cb, sb, r, k1, k2;
        bit [31:0] pa, pb;
        t_out_beat res;
        t_out_beat tris[$];
        bit        cfg_ok;
        i = req.stack_index;
        j = req.sector_index;
        ns = sph_sectors;
        nt = sph_stacks;
        r = sph_radius;
        cfg_ok = ns != 0 && ns <= 256 && nt != 0 && nt <= 256;
        res = '0;
        if (req.opcode == OP_VERTEX) begin
            if (!cfg_ok || i > nt || j > ns) begin
                res.kind = KIND_ERR;
            end else begin
                pb = 32'((j << 32) / ns);
                pa = 32'h4000_0000 - 32'((i << 31) / nt);
                phase_trig(pa, ca, sa);
                phase_trig(pb, cb, sb);
                res.kind   = KIND_VTX;
                res.pos_x  = 16'(round_sh(r * ca * cb, 28));
                res.pos_y  = 16'(round_sh(r * ca * sb, 28));
                res.pos_z  = 16'(round_sh(r * sa, 14));
                res.norm_x = 16'(round_sh(ca * cb, 14));
                res.norm_y = 16'(round_sh(ca * sb, 14));
                res.norm_z = 16'(sa);
                res.tex_u  = 16'((j * 32768) / ns);
                res.tex_v  = 16'((i * 32768) / nt);
            end
            mesh_expected = {mesh_expected, res};
        end else begin
            if (!cfg_ok || i >= nt || j >= ns) begin
                res.kind = KIND_ERR;
                mesh_expected = {mesh_expected, res};
            end else begin
                k1 = i * (ns + 1) + j;
                k2 = k1 + ns + 1;
                if (i != 0) begin
                    res = '0;
                    res.kind = KIND_MORE;
                    res.tri_a = 17'(k1); res.tri_b = 17'(k2); res.tri_c = 17'(k1 + 1);
                    tris = {tris, res};
                end
                if (i != nt - 1) begin
                    res = '0;
                    res.kind = KIND_MORE;
                    res.tri_a = 17'(k1 + 1); res.tri_b = 17'(k2); res.tri_c = 17'(k2 + 1);
                    tris = {tris, res};
                end
                if (tris.size() > 0) tris[tris.size() - 1].kind = KIND_LAST;
                mesh_expected = {mesh_expected, tris};
            end
        end
    endtask

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_request(input bit op, input int si, input int sj);
        t_in_beat req;
        req.opcode = op;
        req.stack_index = si[8:0];
        req.sector_index = sj[8:0];
        i_in = req;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_mesh(req);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_gapped(input bit op, input int si, input int sj, input bit gaps);
        int g = gaps ? gap_len() : 0;
        repeat (g) @(negedge i_clk);
        send_request(op, si, sj);
    endtask

    task automatic drain_mesh();
        while (mesh_expected.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_index = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_RADIUS:  sph_radius = val & 32'h7FFF;
            REG_SECTORS: sph_sectors = val & 32'h1FF;
            default:     sph_stacks = val & 32'h1FF;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_sphere(input int unsigned rad, input int unsigned ns, input int unsigned nt);
        drain_mesh();
        write_reg(REG_RADIUS, rad);
        write_reg(REG_SECTORS, ns);
        write_reg(REG_STACKS, nt);
    endtask

    task automatic test_directed();
        send_request(OP_VERTEX, 0, 0);
        send_request(OP_VERTEX, 16, 32);
        send_request(OP_VERTEX, 8, 8);
        send_request(OP_VERTEX, 17, 0);
        send_request(OP_VERTEX, 0, 33);
        send_request(OP_VERTEX, 511, 511);
        send_request(OP_CELL, 0, 0);
        send_request(OP_CELL, 15, 31);
        send_request(OP_CELL, 7, 5);
        send_request(OP_CELL, 16, 0);
        send_request(OP_CELL, 0, 32);
        send_request(OP_CELL, 511, 511);
        set_sphere(0, 256, 256);
        send_request(OP_VERTEX, 128, 77);
        send_request(OP_CELL, 255, 255);
        send_request(OP_VERTEX, 256, 256);
        set_sphere(32767, 1, 1);
        send_request(OP_CELL, 0, 0);
        send_request(OP_VERTEX, 1, 1);
        send_request(OP_VERTEX, 0, 0);
        set_sphere(16384, 0, 257);
        send_request(OP_VERTEX, 0, 0);
        send_request(OP_CELL, 0, 0);
        set_sphere(16384, 300, 4);
        send_request(OP_VERTEX, 1, 1);
    endtask

    task automatic test_random(input int count);
        int ns, nt;
        for (int n = 0; n < count; n++) begin
            ns = sph_sectors;
            nt = sph_stacks;
            if ($urandom_range(0, 9) == 0)
                send_gapped($urandom_range(0, 1), $urandom_range(0, 511),
                            $urandom_range(0, 511), 1'b1);
            else if ($urandom_range(0, 1) == 0)
                send_gapped(OP_VERTEX, $urandom_range(0, nt), $urandom_range(0, ns), 1'b1);
            else
                send_gapped(OP_CELL, $urandom_range(0, nt > 0 ? nt - 1 : 0),
                            $urandom_range(0, ns > 0 ? ns - 1 : 0), 1'b1);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int n = 0; n < 120; n++)
            send_request($urandom_range(0, 1), $urandom_range(0, sph_stacks - 1),
                         $urandom_range(0, sph_sectors - 1));
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else if (!out_idle_en) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) < 70) ||
                           ($urandom_range(0, 99) < 5 ? 1'b0 : 1'b0);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (mesh_expected.size() == 0) begin
                $error("unexpected beat kind=%0d", o_out.kind);
                fail_count++;
            end else begin
                want = mesh_expected.pop_front();
                if (o_out.kind != want.kind) begin
                    $error("kind exp %0d got %0d", want.kind, o_out.kind); fail_count++;
                end
                if (o_out.pos_x != want.pos_x) begin
                    $error("pos_x exp %0d got %0d", want.pos_x, o_out.pos_x); fail_count++;
                end
                if (o_out.pos_y != want.pos_y) begin
                    $error("pos_y exp %0d got %0d", want.pos_y, o_out.pos_y); fail_count++;
                end
                if (o_out.pos_z != want.pos_z) begin
                    $error("pos_z exp %0d got %0d", want.pos_z, o_out.pos_z); fail_count++;
                end
                if (o_out.norm_x != want.norm_x) begin
                    $error("norm_x exp %0d got %0d", want.norm_x, o_out.norm_x); fail_count++;
                end
                if (o_out.norm_y != want.norm_y) begin
                    $error("norm_y exp %0d got %0d", want.norm_y, o_out.norm_y); fail_count++;
                end
                if (o_out.norm_z != want.norm_z) begin
                    $error("norm_z exp %0d got %0d", want.norm_z, o_out.norm_z); fail_count++;
                end
                if (o_out.tex_u != want.tex_u) begin
                    $error("tex_u exp %0d got %0d", want.tex_u, o_out.tex_u); fail_count++;
                end
                if (o_out.tex_v != want.tex_v) begin
                    $error("tex_v exp %0d got %0d", want.tex_v, o_out.tex_v); fail_count++;
                end
                if (o_out.tri_a != want.tri_a) begin
                    $error("tri_a exp %0d got %0d", want.tri_a, o_out.tri_a); fail_count++;
                end
                if (o_out.tri_b != want.tri_b) begin
                    $error("tri_b exp %0d got %0d", want.tri_b, o_out.tri_b); fail_count++;
                end
                if (o_out.tri_c != want.tri_c) begin
                    $error("tri_c exp %0d got %0d", want.tri_c, o_out.tri_c); fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        sph_radius = RADIUS_RST;
        sph_sectors = SECTORS_RST;
        sph_stacks = STACKS_RST;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        set_sphere(16384, 32, 16);
        test_backpressure();
        set_sphere($urandom_range(1, 32767), 256, 256);
        test_random(500);
        set_sphere($urandom_range(1, 32767), 3, 2);
        test_random(400);
        set_sphere(1, $urandom_range(1, 256), $urandom_range(1, 256));
        test_random(400);
        out_idle_en = 1'b0;
        set_sphere(32767, 7, 1);
        test_random(150);
        out_idle_en = 1'b1;
        set_sphere($urandom_range(1, 32767), $urandom_range(1, 511), $urandom_range(1, 511));
        test_random(330);
        drain_mesh();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
